// ----- rtl/mdgr_pkg.sv -----
// Shared types, status codes and the CRC byte step for the MOT data group reassembler.
package mdgr_pkg;

  // group outcome codes
  localparam logic [2:0] GS_CRC_BAD   = 3'd0;
  localparam logic [2:0] GS_NOT_MOT   = 3'd1;
  localparam logic [2:0] GS_HDR_OK    = 3'd2;
  localparam logic [2:0] GS_HDR_RESET = 3'd3;
  localparam logic [2:0] GS_BODY_OK   = 3'd4;
  localparam logic [2:0] GS_BODY_RST  = 3'd5;
  localparam logic [2:0] GS_OTHER     = 3'd6;
  localparam logic [2:0] GS_MALFORMED = 3'd7;

  // data group types
  localparam logic [3:0] DG_HEADER = 4'd3;
  localparam logic [3:0] DG_BODY   = 4'd4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int SEG_W = 13;

  // header fields captured while a group streams in
  typedef struct packed {
    logic [7:0] g0;
    logic [7:0] seg_hi;
    logic [7:0] seg_lo;
    logic [7:0] ua;
    logic [7:0] tid_hi;
    logic [7:0] tid_lo;
    logic [7:0] sz_hi;
    logic [7:0] sz_lo;
    logic [4:0] seg_pos;
    logic [4:0] ua_pos;
    logic [4:0] size_pos;
    logic       crc_ok;
  } grp_hdr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/mdgr_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module mdgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mdgr_parse.sv -----
// Streaming group parser: byte count, running CRC and header field capture.
module mdgr_parse #(
  parameter int GROUP_BYTES = 8192
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             clear,
  input  logic [7:0]                       byte_in,
  output logic [$clog2(GROUP_BYTES+1)-1:0] count,
  output logic                             ovf,
  output mdgr_pkg::grp_hdr_t               hdr
);
  import mdgr_pkg::*;

  localparam int CW = $clog2(GROUP_BYTES + 1);

  logic [15:0] crc;
  logic [7:0]  d1, d2;
  logic [7:0]  g0, seg_hi, seg_lo, ua, tid_hi, tid_lo, sz_hi, sz_lo;
  logic [4:0]  seg_pos, ua_pos, size_pos;
  logic [3:0]  skip;

  always_comb begin
    seg_pos  = g0[7] ? 5'd4 : 5'd2;
    ua_pos   = seg_pos + (g0[5] ? 5'd2 : 5'd0);
    skip     = (ua[3:0] >= 4'd2) ? ua[3:0] - 4'd2 : 4'd0;
    size_pos = ua_pos + (g0[4] ? (5'd3 + 5'(skip)) : 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      ovf   <= 1'b0;
      crc   <= CRC_INIT;
    end else if (push) begin
      if (count < CW'(GROUP_BYTES)) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
      // CRC trails the stream by two bytes so the check bytes stay out
      if (count >= CW'(2)) begin
        crc <= crc_byte(crc, d2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      d2 <= d1;
      d1 <= byte_in;
      if (count == '0)                          g0     <= byte_in;
      if (count == CW'(seg_pos))                seg_hi <= byte_in;
      if (count == CW'(seg_pos) + CW'(1))       seg_lo <= byte_in;
      if (count == CW'(ua_pos))                 ua     <= byte_in;
      if (count == CW'(ua_pos) + CW'(1))        tid_hi <= byte_in;
      if (count == CW'(ua_pos) + CW'(2))        tid_lo <= byte_in;
      if (count == CW'(size_pos))               sz_hi  <= byte_in;
      if (count == CW'(size_pos) + CW'(1))      sz_lo  <= byte_in;
    end
  end

  always_comb begin
    hdr.g0       = g0;
    hdr.seg_hi   = seg_hi;
    hdr.seg_lo   = seg_lo;
    hdr.ua       = ua;
    hdr.tid_hi   = tid_hi;
    hdr.tid_lo   = tid_lo;
    hdr.sz_hi    = sz_hi;
    hdr.sz_lo    = sz_lo;
    hdr.seg_pos  = seg_pos;
    hdr.ua_pos   = ua_pos;
    hdr.size_pos = size_pos;
    hdr.crc_ok   = (~crc) == {d2, d1};
  end

endmodule

// ----- rtl/mot_data_group_reassembler_top.sv -----
// Top level of the MOT data group reassembler: sequencer, part state and stores.
//
// Group bytes (tuser 0) are taken one per cycle while the input is not held off and
// go to the group buffer while the CRC and the header fields are tracked on the fly.
// The last byte of a group (tlast) starts the group check: an evaluation state
// decides, then, when a segment is appended, its bytes are copied from the group
// buffer into the header or body store (bound by the single group buffer read port)
// and the copy drains, a finish state settles the part state, the header read states
// fetch the content type bytes when an object completes, and the output register is
// loaded. A body read (tuser 1) registers the body store data in a read state. The
// input is held off from the last byte of a group until its result is in the output
// register; a result still unread when the next one is ready holds that one, and the
// input with it, until it is taken. No clearing pass is needed after reset.
module mot_data_group_reassembler_top #(
  parameter int GROUP_BYTES  = 8192,
  parameter int HEADER_BYTES = 1024,
  parameter int BODY_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_addr[23:8]
  input  logic        s_axis_tuser,  // func
  input  logic        s_axis_tlast,  // group_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // group_status[2:0], crc_ok[3], object_done[4], content_type[10:5],
  // content_subtype[19:11], body_length[36:20], header_ready[37], body_ready[38],
  // read_data[46:39], zero[47]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser   // result_kind
);
  import mdgr_pkg::*;

  localparam int CW  = $clog2(GROUP_BYTES + 1);
  localparam int GAW = $clog2(GROUP_BYTES);
  localparam int HAW = $clog2(HEADER_BYTES);
  localparam int HFW = $clog2(HEADER_BYTES + 1);
  localparam int BAW = $clog2(BODY_BYTES);
  localparam int BFW = $clog2(BODY_BYTES + 1);
  localparam int M1  = (HFW > BFW) ? HFW : BFW;
  localparam int M2  = (M1 > CW) ? M1 : CW;
  localparam int SW  = ((M2 > 17) ? M2 : 17) + 2;
  localparam int PW  = (HAW > BAW) ? HAW : BAW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EVAL = 4'd1;
  localparam logic [3:0] ST_COPY = 4'd2;
  localparam logic [3:0] ST_FIN  = 4'd3;
  localparam logic [3:0] ST_HRD0 = 4'd4;
  localparam logic [3:0] ST_HRD1 = 4'd5;
  localparam logic [3:0] ST_HRD2 = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_APPEND = 2'd2;

  logic [3:0] state;

  logic            accept_in, push;
  logic [CW-1:0]   cnt;
  logic            ovf;
  grp_hdr_t        ph;

  // part state
  logic [HFW-1:0]  h_fill;
  logic [15:0]     h_last;
  logic            h_ok, h_ready;
  logic [BFW-1:0]  b_fill;
  logic [15:0]     b_last;
  logic            b_ok, b_ready;
  logic [15:0]     cur_tid;
  logic [16:0]     done_len;

  // copy engine
  logic [GAW-1:0]   rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [SEG_W-1:0] rem;
  logic             wr_pend;
  logic             copy_h;

  // result staging
  logic        r_kind;
  logic [2:0]  r_status;
  logic        r_crc, r_done, rd_ok;
  logic [5:0]  r_ctype;
  logic [8:0]  r_csub;
  logic [16:0] r_blen;
  logic [7:0]  r_rdata;
  logic [7:0]  b5;

  // memories
  logic           buf_we;
  logic [7:0]     buf_rdata;
  logic           h_we, b_we;
  logic [HAW-1:0] h_raddr;
  logic [7:0]     h_rdata, b_rdata;

  // evaluation
  logic             crcf, segf, uaf, tidf, is_h, seg0, fail_seq, fail_tid, fit, ok_eff;
  logic             sel_ok, sel_ready, short_n;
  logic [3:0]       dg_type;
  logic [15:0]      tid, seg_num, sel_last;
  logic [SEG_W-1:0] seg_size;
  logic [SW-1:0]    n_w, sel_fill, base, data_end, start_w, cap;
  logic [2:0]       ev_status;
  logic [1:0]       ev_act;
  logic             ready_new;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign push          = accept_in && !s_axis_tuser;
  assign buf_we        = push && (cnt < CW'(GROUP_BYTES));

  mdgr_parse #(.GROUP_BYTES(GROUP_BYTES)) u_parse (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .clear   (state == ST_EVAL),
    .byte_in (s_axis_tdata[7:0]),
    .count   (cnt),
    .ovf     (ovf),
    .hdr     (ph)
  );

  mdgr_ram #(.WIDTH(8), .DEPTH(GROUP_BYTES)) u_group_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cnt[GAW-1:0]),
    .wdata (s_axis_tdata[7:0]),
    .raddr (rd_ptr),
    .rdata (buf_rdata)
  );

  assign h_we    = (state == ST_COPY) && wr_pend && copy_h;
  assign b_we    = (state == ST_COPY) && wr_pend && !copy_h;
  assign h_raddr = (state == ST_HRD0) ? HAW'(5) : HAW'(6);

  mdgr_ram #(.WIDTH(8), .DEPTH(HEADER_BYTES)) u_header_store (
    .clk   (clk),
    .we    (h_we),
    .waddr (wr_ptr[HAW-1:0]),
    .wdata (buf_rdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mdgr_ram #(.WIDTH(8), .DEPTH(BODY_BYTES)) u_body_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_ptr[BAW-1:0]),
    .wdata (buf_rdata),
    .raddr (BAW'(s_axis_tdata[23:8])),
    .rdata (b_rdata)
  );

  always_comb begin
    crcf      = ph.g0[6];
    segf      = ph.g0[5];
    uaf       = ph.g0[4];
    dg_type   = ph.g0[3:0];
    tidf      = ph.ua[4];
    tid       = {ph.tid_hi, ph.tid_lo};
    seg_num   = {1'b0, ph.seg_hi[6:0], ph.seg_lo};
    seg_size  = {ph.sz_hi[4:0], ph.sz_lo};
    is_h      = (dg_type == DG_HEADER);
    sel_fill  = is_h ? SW'(h_fill) : SW'(b_fill);
    sel_last  = is_h ? h_last : b_last;
    sel_ok    = is_h ? h_ok : b_ok;
    sel_ready = is_h ? h_ready : b_ready;
    cap       = is_h ? SW'(HEADER_BYTES) : SW'(BODY_BYTES);
    seg0      = (seg_num == 16'd0);
    fail_tid  = seg0 && !is_h && (cur_tid != tid);
    fail_seq  = !seg0 && (((sel_last + 16'd1) != seg_num) || (cur_tid != tid));
    base      = seg0 ? '0 : sel_fill;
    n_w       = SW'(cnt);
    data_end  = crcf ? n_w - SW'(2) : n_w;
    start_w   = SW'(ph.size_pos) + SW'(2);
    fit       = (start_w + SW'(seg_size) <= data_end) && (base + SW'(seg_size) <= cap);
    ok_eff    = seg0 || sel_ok;
    ready_new = (!seg0 && sel_ready) || (ph.seg_hi[7] && ok_eff);
    short_n   = ovf || (cnt < CW'(2));

    ev_act = ACT_NONE;
    if (short_n) begin
      ev_status = GS_MALFORMED;
    end else if (segf && (CW'(ph.seg_pos) + CW'(2) > cnt)) begin
      ev_status = GS_MALFORMED;
    end else if (uaf && (CW'(ph.ua_pos) + CW'(3) > cnt)) begin
      ev_status = GS_MALFORMED;
    end else if (CW'(ph.size_pos) > cnt) begin
      ev_status = GS_MALFORMED;
    end else if (crcf && !ph.crc_ok) begin
      ev_status = GS_CRC_BAD;
    end else if (CW'(ph.size_pos) + CW'(2) > cnt) begin
      ev_status = GS_MALFORMED;
    end else if (!(segf && uaf && tidf)) begin
      ev_status = GS_NOT_MOT;
    end else if (!is_h && (dg_type != DG_BODY)) begin
      ev_status = GS_OTHER;
    end else if (fail_tid || fail_seq || !fit) begin
      ev_status = is_h ? GS_HDR_RESET : GS_BODY_RST;
      ev_act    = ACT_CLEAR;
    end else begin
      ev_status = is_h ? GS_HDR_OK : GS_BODY_OK;
      ev_act    = ACT_APPEND;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      h_fill        <= '0;
      h_last        <= 16'hFFFF;
      h_ok          <= 1'b0;
      h_ready       <= 1'b0;
      b_fill        <= '0;
      b_last        <= 16'hFFFF;
      b_ok          <= 1'b0;
      b_ready       <= 1'b0;
      cur_tid       <= '0;
      done_len      <= '0;
      m_axis_tvalid <= 1'b0;
      wr_pend       <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_in && s_axis_tuser) begin
            state <= ST_RD;
          end else if (push && s_axis_tlast) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (ev_act != ACT_NONE && seg0 && is_h) begin
            cur_tid <= tid;
          end
          if (ev_act == ACT_CLEAR) begin
            if (is_h) begin
              h_fill <= '0; h_last <= 16'hFFFF; h_ok <= 1'b0; h_ready <= 1'b0;
            end else begin
              b_fill <= '0; b_last <= 16'hFFFF; b_ok <= 1'b0; b_ready <= 1'b0;
            end
          end else if (ev_act == ACT_APPEND) begin
            if (is_h) begin
              h_fill  <= HFW'(base + SW'(seg_size));
              h_last  <= seg_num;
              h_ok    <= ok_eff;
              h_ready <= ready_new;
            end else begin
              b_fill  <= BFW'(base + SW'(seg_size));
              b_last  <= seg_num;
              b_ok    <= ok_eff;
              b_ready <= ready_new;
            end
          end
          wr_pend <= 1'b0;
          state   <= (ev_act == ACT_APPEND && seg_size != '0) ? ST_COPY : ST_FIN;
        end
        ST_COPY: begin
          wr_pend <= (rem != '0);
          if (rem == '0 && !wr_pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= (h_ready && b_ready) ? ST_HRD0 : ST_OUT;
        end
        ST_HRD0: state <= ST_HRD1;
        ST_HRD1: state <= ST_HRD2;
        ST_HRD2: begin
          done_len <= 17'(b_fill);
          h_fill <= '0; h_last <= 16'hFFFF; h_ok <= 1'b0; h_ready <= 1'b0;
          b_fill <= '0; b_last <= 16'hFFFF; b_ok <= 1'b0; b_ready <= 1'b0;
          state  <= ST_OUT;
        end
        ST_RD: state <= ST_OUT;
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        r_kind  <= s_axis_tuser;
        r_done  <= 1'b0;
        r_ctype <= '0;
        r_csub  <= '0;
        r_blen  <= '0;
        r_rdata <= '0;
        r_status <= '0;
        r_crc   <= 1'b0;
        rd_ok   <= (SW'(s_axis_tdata[23:8]) < SW'(done_len))
                && (SW'(s_axis_tdata[23:8]) < SW'(BODY_BYTES));
      end
      ST_EVAL: begin
        r_status <= ev_status;
        r_crc    <= !short_n && ph.crc_ok;
        rd_ptr   <= GAW'(start_w);
        wr_ptr   <= PW'(base);
        rem      <= seg_size;
        copy_h   <= is_h;
      end
      ST_COPY: begin
        // issue buffer reads ahead, write the store in the cycle after each read
        if (rem != '0) begin
          rd_ptr <= rd_ptr + GAW'(1);
          rem    <= rem - SEG_W'(1);
        end
        if (wr_pend) begin
          wr_ptr <= wr_ptr + PW'(1);
        end
      end
      ST_HRD1: b5 <= h_rdata;
      ST_HRD2: begin
        r_done  <= 1'b1;
        r_ctype <= (h_fill > HFW'(5)) ? b5[6:1] : 6'd0;
        r_csub  <= {(h_fill > HFW'(5)) ? b5[0] : 1'b0,
                    (h_fill > HFW'(6)) ? h_rdata : 8'd0};
        r_blen  <= 17'(b_fill);
      end
      ST_RD: r_rdata <= rd_ok ? b_rdata : 8'd0;
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tuser <= r_kind;
          m_axis_tdata <= {1'b0, r_rdata, b_ready && !r_kind, h_ready && !r_kind,
                           r_blen, r_csub, r_ctype, r_done, r_crc, r_status};
        end
      end
      default: ;
    endcase
  end

  a_copy_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && rem == '0 && !wr_pend) |=> (state == ST_FIN))
    else $error("copy did not finish");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> (!m_axis_tdata[37] && !m_axis_tdata[38]))
    else $error("completed object left a part ready");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[38:0] == '0))
    else $error("read result carries group fields");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(GROUP_BYTES))
    else $error("group count past buffer size");

  a_store_writes: assert property (@(posedge clk) disable iff (rst)
    (h_we || b_we) |-> (state == ST_COPY && $past(state == ST_COPY || state == ST_EVAL)))
    else $error("store write outside copy");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the MOT data group reassembler: stream stimulus and a predictor.
module tb_top;
  import mdgr_pkg::*;

  typedef bit [7:0] u8;

  // one data group as the sender builds it
  typedef struct {
    bit        ext;
    bit        crcf;
    bit        segf;
    bit        uaf;
    bit        tidf;
    bit        lastf;
    bit [3:0]  gtype;
    bit [3:0]  li;
    bit [14:0] segn;
    bit [15:0] tid;
    int        pay;
    int        size_field;
    bit        bad_crc;
    int        cut;
  } group_desc_t;

  typedef struct {
    bit        kind;
    bit [2:0]  status;
    bit        crc_ok;
    bit        done;
    bit [5:0]  ctype;
    bit [8:0]  csub;
    bit [16:0] blen;
    bit        hrdy;
    bit        brdy;
    bit [7:0]  rdata;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  mot_data_group_reassembler_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  u8         grp_buf [8192];
  int        grp_cnt;
  bit        grp_over;
  u8         hdr_mem [1024];
  u8         body_mem [65536];
  int        part_fill [2];
  bit [15:0] part_last [2];
  bit        part_ok [2];
  bit        part_rdy [2];
  bit [15:0] cur_tid;
  int        done_len;

  outcome_t  expected_q[$];
  int        errors;
  int        idle_pct;
  int        bytes_sent;

  function automatic void part_reset(int p);
    part_fill[p] = 0;
    part_last[p] = 16'hFFFF;
    part_ok[p]   = 0;
    part_rdy[p]  = 0;
  endfunction

  function automatic bit [15:0] crc16(const ref u8 b[8192], input int len);
    bit [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < len; i++) begin
      c ^= {b[i], 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return ~c;
  endfunction

  function automatic int hdr_bits(int first, int count);
    int v;
    v = 0;
    for (int k = first; k < first + count; k++) begin
      v = v << 1;
      if ((k >> 3) < part_fill[0]) v |= (hdr_mem[k >> 3] >> (7 - (k & 7))) & 1;
    end
    return v;
  endfunction

  function automatic bit [2:0] group_outcome(int n, output bit crc_ok);
    int        pos, skip, seg_size, data_end, p, cap;
    bit        crcf, segf, uaf, tidf, lastf;
    bit [3:0]  gtype;
    bit [15:0] segn, tid;
    crc_ok = 0;
    tidf = 0; lastf = 0; segn = 0; tid = 0;
    if (grp_over || n < 2) return GS_MALFORMED;
    crc_ok = crc16(grp_buf, n - 2) == {grp_buf[n-2], grp_buf[n-1]};
    crcf  = grp_buf[0][6];
    segf  = grp_buf[0][5];
    uaf   = grp_buf[0][4];
    gtype = grp_buf[0][3:0];
    pos = grp_buf[0][7] ? 4 : 2;
    if (segf) begin
      if (pos + 2 > n) return GS_MALFORMED;
      lastf = grp_buf[pos][7];
      segn  = {1'b0, grp_buf[pos][6:0], grp_buf[pos+1]};
      pos += 2;
    end
    if (uaf) begin
      if (pos + 3 > n) return GS_MALFORMED;
      tidf = grp_buf[pos][4];
      skip = grp_buf[pos][3:0];
      skip = skip >= 2 ? skip - 2 : 0;
      tid  = {grp_buf[pos+1], grp_buf[pos+2]};
      pos += 3 + skip;
    end
    if (pos > n) return GS_MALFORMED;
    if (crcf && !crc_ok) return GS_CRC_BAD;
    if (pos + 2 > n) return GS_MALFORMED;
    seg_size = {grp_buf[pos][4:0], grp_buf[pos+1]};
    pos += 2;
    if (!(segf && uaf && tidf)) return GS_NOT_MOT;
    if (gtype != DG_HEADER && gtype != DG_BODY) return GS_OTHER;
    data_end = crcf ? n - 2 : n;
    p   = (gtype == DG_HEADER) ? 0 : 1;
    cap = (p == 0) ? 1024 : 65536;
    if (segn == 0) begin
      part_reset(p);
      if (p == 0) cur_tid = tid;
      if (cur_tid != tid) return GS_BODY_RST;
      part_ok[p] = 1;
    end else if (16'(part_last[p] + 16'd1) != segn || cur_tid != tid) begin
      part_reset(p);
      return p == 0 ? GS_HDR_RESET : GS_BODY_RST;
    end
    if (pos + seg_size > data_end || part_fill[p] + seg_size > cap) begin
      part_reset(p);
      return p == 0 ? GS_HDR_RESET : GS_BODY_RST;
    end
    for (int i = 0; i < seg_size; i++) begin
      if (p == 0) hdr_mem[part_fill[p] + i] = grp_buf[pos + i];
      else body_mem[part_fill[p] + i] = grp_buf[pos + i];
    end
    part_fill[p] += seg_size;
    part_last[p] = segn;
    if (lastf && part_ok[p]) part_rdy[p] = 1;
    return p == 0 ? GS_HDR_OK : GS_BODY_OK;
  endfunction

  // advance the predictor by one accepted word
  function automatic void predict_word(bit func, u8 d, bit last, bit [15:0] addr);
    outcome_t o;
    bit       ok;
    o = '{default: 0};
    if (func) begin
      o.kind = 1;
      if (addr < done_len) o.rdata = body_mem[addr];
      expected_q.push_back(o);
      return;
    end
    if (grp_cnt < 8192) begin
      grp_buf[grp_cnt] = d;
      grp_cnt++;
    end else grp_over = 1;
    if (!last) return;
    o.status = group_outcome(grp_cnt, ok);
    o.crc_ok = ok;
    grp_cnt = 0;
    grp_over = 0;
    if (part_rdy[0] && part_rdy[1]) begin
      o.done  = 1;
      o.ctype = 6'(hdr_bits(41, 6));
      o.csub  = 9'(hdr_bits(47, 9));
      done_len = part_fill[1];
      o.blen  = 17'(done_len);
      part_reset(0);
      part_reset(1);
    end
    o.hrdy = part_rdy[0];
    o.brdy = part_rdy[1];
    expected_q.push_back(o);
  endfunction

  task automatic send_word(bit func, u8 d, bit last, bit [15:0] addr);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, d};
    s_axis_tuser  <= func;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_word(func, d, last, addr);
    bytes_sent++;
  endtask

  task automatic read_body(bit [15:0] addr);
    send_word(1'b1, u8'($urandom), $urandom_range(1), addr);
  endtask

  task automatic send_group(group_desc_t g);
    u8         q[$];
    bit [15:0] c;
    int        sz;
    q.push_back({g.ext, g.crcf, g.segf, g.uaf, g.gtype});
    q.push_back(u8'($urandom));
    if (g.ext) begin
      q.push_back(u8'($urandom));
      q.push_back(u8'($urandom));
    end
    if (g.segf) begin
      q.push_back({g.lastf, g.segn[14:8]});
      q.push_back(g.segn[7:0]);
    end
    if (g.uaf) begin
      q.push_back({3'($urandom), g.tidf, g.li});
      q.push_back(g.tid[15:8]);
      q.push_back(g.tid[7:0]);
      for (int i = 2; i < g.li; i++) q.push_back(u8'($urandom));
    end
    sz = (g.size_field < 0) ? g.pay : g.size_field;
    q.push_back({3'($urandom), 5'(sz >> 8)});
    q.push_back(u8'(sz));
    for (int i = 0; i < g.pay; i++) q.push_back(u8'($urandom));
    if (g.crcf) begin
      c = 16'hFFFF;
      foreach (q[i]) begin
        c ^= {q[i], 8'h00};
        for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      c = ~c;
      if (g.bad_crc) c ^= 16'(1 << $urandom_range(15));
      q.push_back(c[15:8]);
      q.push_back(c[7:0]);
    end
    if (g.cut > 0 && g.cut < q.size()) q = q[0:g.cut-1];
    foreach (q[i]) send_word(1'b0, q[i], i == q.size() - 1, 16'($urandom));
  endtask

  function automatic group_desc_t mot_group(bit [3:0] gtype, int segn, bit lastf,
                                            bit [15:0] tid, int pay);
    group_desc_t g;
    g.ext = $urandom_range(1);
    g.crcf = $urandom_range(1);
    g.segf = 1; g.uaf = 1; g.tidf = 1;
    g.lastf = lastf;
    g.gtype = gtype;
    g.li = $urandom_range(15);
    g.segn = segn;
    g.tid = tid;
    g.pay = pay;
    g.size_field = -1;
    g.bad_crc = 0;
    g.cut = 0;
    return g;
  endfunction

  // a whole object: header segments, body segments, last header segment; may inject a fault
  task automatic send_object(bit [15:0] tid, int hsegs, int bsegs, int fault_pct);
    group_desc_t g;
    for (int i = 0; i < hsegs + bsegs; i++) begin
      if (i < hsegs - 1) g = mot_group(DG_HEADER, i, 0, tid, $urandom_range(8));
      else if (i < hsegs + bsegs - 1)
        g = mot_group(DG_BODY, i - hsegs + 1, i == hsegs + bsegs - 2, tid,
                      $urandom_range(40));
      else g = mot_group(DG_HEADER, hsegs - 1, 1, tid, $urandom_range(12));
      if ($urandom_range(99) < fault_pct) begin
        case ($urandom_range(7))
          0: begin g.crcf = 1; g.bad_crc = 1; end
          1: g.segn = g.segn + $urandom_range(3, 1);
          2: g.tid = ~g.tid;
          3: g.gtype = $urandom_range(15);
          4: begin g.tidf = 0; g.segf = $urandom_range(1); g.uaf = $urandom_range(1); end
          5: g.cut = $urandom_range(12);
          6: g.size_field = g.pay + $urandom_range(9, 1);
          default: g.size_field = $urandom_range(8191);
        endcase
      end
      send_group(g);
    end
  endtask

  // drop valid and hold until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic test_basic_object();
    send_object(16'h0000, 1, 1, 0);
    send_object(16'hFFFF, 2, 2, 0);
    read_body(16'h0000);
    read_body(16'hFFFF);
  endtask

  task automatic test_faults();
    group_desc_t g;
    send_word(1'b0, 8'hFF, 1'b1, 16'h0000);            // one-byte group
    g = mot_group(DG_HEADER, 0, 0, 16'h1234, 4); g.cut = 3; send_group(g);
    g = mot_group(DG_HEADER, 0, 0, 16'h1234, 4); g.crcf = 1; g.bad_crc = 1; send_group(g);
    g = mot_group(DG_HEADER, 0, 0, 16'h1234, 4); g.tidf = 0; send_group(g);
    g = mot_group(4'd5, 0, 0, 16'h1234, 4); send_group(g);
    g = mot_group(DG_HEADER, 0, 0, 16'h1234, 4); g.size_field = 8191; send_group(g);
    g = mot_group(DG_BODY, 0, 1, 16'h4321, 4); send_group(g);
    g = mot_group(DG_HEADER, 0, 0, 16'h1234, 4); send_group(g);
    g = mot_group(DG_HEADER, 2, 1, 16'h1234, 4); send_group(g);
  endtask

  task automatic test_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 800) begin
      // long stretch without idling on either side
      idle_pct = (bytes_sent - start > 300 && bytes_sent - start < 500) ? 0 : 34;
      send_object(16'($urandom), $urandom_range(3, 1), $urandom_range(4, 1),
                  $urandom_range(1) ? 0 : 20);
      repeat ($urandom_range(4)) read_body(done_len > 0 && $urandom_range(3) != 0 ?
                                           16'($urandom_range(done_len - 1)) :
                                           16'($urandom));
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst) m_axis_tready <= 1'b0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) report("unexpected word", m_axis_tdata[31:0], 0);
        else begin
          e = expected_q.pop_front();
          if (m_axis_tuser !== e.kind) report("result_kind", m_axis_tuser, e.kind);
          if (m_axis_tdata[2:0] !== e.status) report("group_status", m_axis_tdata[2:0], e.status);
          if (m_axis_tdata[3] !== e.crc_ok) report("crc_ok", m_axis_tdata[3], e.crc_ok);
          if (m_axis_tdata[4] !== e.done) report("object_done", m_axis_tdata[4], e.done);
          if (m_axis_tdata[10:5] !== e.ctype) report("content_type", m_axis_tdata[10:5], e.ctype);
          if (m_axis_tdata[19:11] !== e.csub)
            report("content_subtype", m_axis_tdata[19:11], e.csub);
          if (m_axis_tdata[36:20] !== e.blen) report("body_length", m_axis_tdata[36:20], e.blen);
          if (m_axis_tdata[37] !== e.hrdy) report("header_ready", m_axis_tdata[37], e.hrdy);
          if (m_axis_tdata[38] !== e.brdy) report("body_ready", m_axis_tdata[38], e.brdy);
          if (m_axis_tdata[46:39] !== e.rdata) report("read_data", m_axis_tdata[46:39], e.rdata);
          if (m_axis_tdata[47] !== 1'b0) report("spare bit", m_axis_tdata[47], 0);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    errors = 0; idle_pct = 34; bytes_sent = 0;
    grp_cnt = 0; grp_over = 0; cur_tid = 0; done_len = 0;
    part_reset(0);
    part_reset(1);
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_object();
    test_faults();
    wait_drained();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
